[sv/uesc_pkg.sv]
// ----------------------------------------------------------------------------
// uesc_pkg
// Shared widths, character codes and hex digit decode for the escape decoder.
// ----------------------------------------------------------------------------
package uesc_pkg;

   // payload widths
   localparam int BYTE_W  = 8;
   localparam int UNIT_W  = 16;
   localparam int COUNT_W = 3;
   localparam int NIBBLE_W = 4;

   // character codes
   localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CHAR_U         = 8'h75;
   localparam logic [BYTE_W-1:0] CHAR_T         = 8'h74;
   localparam logic [BYTE_W-1:0] CHAR_R         = 8'h72;
   localparam logic [BYTE_W-1:0] CHAR_N         = 8'h6E;
   localparam logic [BYTE_W-1:0] CHAR_F         = 8'h66;
   localparam logic [BYTE_W-1:0] CHAR_0         = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9         = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_F   = 8'h46;

   // control codes emitted for the short escapes
   localparam logic [UNIT_W-1:0] UNIT_TAB = 16'd9;
   localparam logic [UNIT_W-1:0] UNIT_LF  = 16'd10;
   localparam logic [UNIT_W-1:0] UNIT_FF  = 16'd12;
   localparam logic [UNIT_W-1:0] UNIT_CR  = 16'd13;

   // value of the letter digits above nine
   localparam logic [NIBBLE_W-1:0] HEX_TEN = 4'd10;

   // hex digit decode: valid flag and nibble value
   typedef struct packed {
      logic                is_hex;
      logic [NIBBLE_W-1:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [BYTE_W-1:0] b);
      hex_digit_type d;
      logic [BYTE_W-1:0] diff;
      d    = '0;
      diff = '0;
      if (b >= CHAR_0 && b <= CHAR_9) begin
         diff     = b - CHAR_0;
         d.is_hex = 1'b1;
         d.value  = diff[NIBBLE_W-1:0];
      end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) begin
         diff     = b - CHAR_LOWER_A;
         d.is_hex = 1'b1;
         d.value  = HEX_TEN + diff[NIBBLE_W-1:0];
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         diff     = b - CHAR_UPPER_A;
         d.is_hex = 1'b1;
         d.value  = HEX_TEN + diff[NIBBLE_W-1:0];
      end
      return d;
   endfunction

endpackage

[sv/uesc_if.sv]
// ----------------------------------------------------------------------------
// uesc_if
// Valid/ready channels of the escape decoder: byte requests and code units.
// ----------------------------------------------------------------------------
interface uesc_req_if;
   logic                        valid;
   logic                        ready;
   logic [uesc_pkg::BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface uesc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [uesc_pkg::UNIT_W-1:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink   (input valid, input code_unit, output ready);
endinterface

[sv/unicode_escape_decoder.sv]
// ----------------------------------------------------------------------------
// unicode_escape_decoder
// Decodes a backslash-escaped byte stream into 16-bit code units.
//
// Takes one byte per clock and turns it into zero or one code unit. Plain
// bytes pass through zero-extended; \t \r \n \f give TAB, CR, LF and FF; \u
// followed by HEX_DIGITS bytes gives the hex value (a non-hex byte in that
// run uses a slot but adds nothing); any other escaped byte comes out as
// itself. A byte waits in the input register while the parser state and the
// result register update, so a code unit is presented from the result
// register once its last byte has passed the input register. A new byte is
// taken every cycle as long as the result register is free or being drained.
// Bytes that only advance the parser (backslash, u, hex digits before the
// last) never wait on the output.
// ----------------------------------------------------------------------------
module unicode_escape_decoder #(
   parameter int HEX_DIGITS = 4
) (
   input  logic       clock,
   input  logic       reset,
   uesc_req_if.sink   req_chan,
   uesc_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_HEX  = 2'd2
   } mode_type;

   localparam logic [uesc_pkg::COUNT_W:0] LastSlot = (uesc_pkg::COUNT_W + 1)'(HEX_DIGITS);

   // input register
   logic                                in_valid_ff;
   logic                                in_valid_in;
   logic [uesc_pkg::BYTE_W-1:0]         in_byte_ff;

   // parser state
   mode_type                            mode_ff;
   mode_type                            mode_in;
   logic [uesc_pkg::COUNT_W-1:0]        count_ff;
   logic [uesc_pkg::COUNT_W-1:0]        count_in;
   logic [uesc_pkg::UNIT_W-1:0]         acc_ff;
   logic [uesc_pkg::UNIT_W-1:0]         acc_in;

   // result register
   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic [uesc_pkg::UNIT_W-1:0]         out_unit_ff;
   logic [uesc_pkg::UNIT_W-1:0]         unit_in;

   logic                                emit;
   logic                                out_free;
   logic                                step;
   uesc_pkg::hex_digit_type             digit;
   logic [uesc_pkg::UNIT_W-1:0]         acc_shifted;
   logic [uesc_pkg::COUNT_W:0]          count_inc;

   // hex digit path
   always_comb begin
      digit       = uesc_pkg::hex_decode(in_byte_ff);
      acc_shifted = digit.is_hex
                    ? {acc_ff[uesc_pkg::UNIT_W-uesc_pkg::NIBBLE_W-1:0], digit.value}
                    : acc_ff;
      count_inc   = {1'b0, count_ff} + 1'b1;
   end

   // parser next state and result
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      unit_in  = {{(uesc_pkg::UNIT_W-uesc_pkg::BYTE_W){1'b0}}, in_byte_ff};
      emit     = 1'b0;
      case (mode_ff)
         MODE_ESC: begin
            if (in_byte_ff == uesc_pkg::CHAR_U) begin
               mode_in  = MODE_HEX;
               count_in = '0;
               acc_in   = '0;
            end else begin
               mode_in = MODE_TEXT;
               emit    = 1'b1;
               case (in_byte_ff)
                  uesc_pkg::CHAR_T: unit_in = uesc_pkg::UNIT_TAB;
                  uesc_pkg::CHAR_R: unit_in = uesc_pkg::UNIT_CR;
                  uesc_pkg::CHAR_N: unit_in = uesc_pkg::UNIT_LF;
                  uesc_pkg::CHAR_F: unit_in = uesc_pkg::UNIT_FF;
                  default:          unit_in = {{(uesc_pkg::UNIT_W-uesc_pkg::BYTE_W){1'b0}},
                                               in_byte_ff};
               endcase
            end
         end
         MODE_HEX: begin
            if (count_inc >= LastSlot) begin
               unit_in  = acc_shifted;
               emit     = 1'b1;
               mode_in  = MODE_TEXT;
               count_in = '0;
               acc_in   = '0;
            end else begin
               acc_in   = acc_shifted;
               count_in = count_inc[uesc_pkg::COUNT_W-1:0];
            end
         end
         default: begin
            if (in_byte_ff == uesc_pkg::CHAR_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               mode_in = MODE_TEXT;
               emit    = 1'b1;
            end
         end
      endcase
   end

   // handshake: a byte leaves the input register unless its result must wait
   always_comb begin
      out_free       = !out_valid_ff || rsp_chan.ready;
      step           = in_valid_ff && (!emit || out_free);
      req_chan.ready = !in_valid_ff || step;
      in_valid_in    = (req_chan.valid && req_chan.ready) || (in_valid_ff && !step);
      out_valid_in   = (step && emit) || (out_valid_ff && !rsp_chan.ready);
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.code_unit = out_unit_ff;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_TEXT;
         count_ff     <= '0;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // result register
         if (step && emit) begin
            out_unit_ff <= unit_in;
         end
         // parser state
         if (step) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            acc_ff   <= acc_in;
         end
         // input register
         if (req_chan.valid && req_chan.ready) begin
            in_byte_ff <= req_chan.in_byte;
         end
      end
   end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the backslash escape decoder.
//
// Streams bytes into the decoder over the request channel and checks every
// code unit against an in-bench prediction of the parser. Directed cases
// cover plain bytes at both ends of the range, the short escapes, escaped
// unknown bytes and hex escapes (mixed case digits, a non-hex slot, a pause
// in the middle). Random streams of mostly well-formed escapes then run
// under three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HEX_DIGITS   = 4;
   localparam int DRAIN_CYCLES = 8;

   // parser state as seen by the prediction
   typedef enum logic [1:0] {
      PS_TEXT = 2'd0,
      PS_ESC  = 2'd1,
      PS_HEX  = 2'd2
   } parse_state_type;

   logic clock;
   logic reset;

   uesc_req_if req_chan ();
   uesc_rsp_if rsp_chan ();

   unicode_escape_decoder #(
      .HEX_DIGITS(HEX_DIGITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // predicted parser state
   parse_state_type                parse_state = PS_TEXT;
   logic [uesc_pkg::COUNT_W-1:0]   digit_slots = '0;
   logic [uesc_pkg::UNIT_W-1:0]    hex_acc     = '0;

   // code units still to come out, oldest first
   logic [uesc_pkg::UNIT_W-1:0]    pending_units[$];
   logic [uesc_pkg::UNIT_W-1:0]    oldest_unit;

   int req_idle_pct  = 7;
   int rsp_idle_pct  = 78;
   int bytes_sent    = 0;
   int units_checked = 0;
   int hex_units     = 0;
   int short_units   = 0;
   int error_count   = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("%0t: run limit reached with %0d code units outstanding", $time,
               pending_units.size());
      $display("FAILURE");
      $finish;
   end

   // predict the code unit, if any, caused by one accepted byte
   function automatic void decode_byte(input logic [uesc_pkg::BYTE_W-1:0] b);
      logic [uesc_pkg::UNIT_W-1:0] unit;
      logic                        emit;
      logic                        is_digit;
      logic [uesc_pkg::BYTE_W-1:0] offset;
      unit     = '0;
      emit     = 1'b0;
      is_digit = 1'b0;
      offset   = '0;
      case (parse_state)
         PS_ESC: begin
            if (b == uesc_pkg::CHAR_U) begin
               parse_state = PS_HEX;
               digit_slots = '0;
               hex_acc     = '0;
            end else begin
               parse_state = PS_TEXT;
               emit        = 1'b1;
               case (b)
                  uesc_pkg::CHAR_T: unit = uesc_pkg::UNIT_TAB;
                  uesc_pkg::CHAR_R: unit = uesc_pkg::UNIT_CR;
                  uesc_pkg::CHAR_N: unit = uesc_pkg::UNIT_LF;
                  uesc_pkg::CHAR_F: unit = uesc_pkg::UNIT_FF;
                  default:          unit = {8'h00, b};
               endcase
               if (b inside {uesc_pkg::CHAR_T, uesc_pkg::CHAR_R, uesc_pkg::CHAR_N,
                             uesc_pkg::CHAR_F})
                  short_units++;
            end
         end
         PS_HEX: begin
            // digit value; a non-hex byte only burns a slot
            if (b >= uesc_pkg::CHAR_0 && b <= uesc_pkg::CHAR_9) begin
               is_digit = 1'b1;
               offset   = b - uesc_pkg::CHAR_0;
            end else if (b >= uesc_pkg::CHAR_LOWER_A && b <= uesc_pkg::CHAR_LOWER_F) begin
               is_digit = 1'b1;
               offset   = b - uesc_pkg::CHAR_LOWER_A + 8'd10;
            end else if (b >= uesc_pkg::CHAR_UPPER_A && b <= uesc_pkg::CHAR_UPPER_F) begin
               is_digit = 1'b1;
               offset   = b - uesc_pkg::CHAR_UPPER_A + 8'd10;
            end
            if (is_digit)
               hex_acc = {hex_acc[uesc_pkg::UNIT_W-5:0], offset[3:0]};
            if (int'(digit_slots) + 1 >= HEX_DIGITS) begin
               emit        = 1'b1;
               unit        = hex_acc;
               parse_state = PS_TEXT;
               digit_slots = '0;
               hex_acc     = '0;
               hex_units++;
            end else begin
               digit_slots = digit_slots + 1'b1;
            end
         end
         default: begin
            if (b == uesc_pkg::CHAR_BACKSLASH) begin
               parse_state = PS_ESC;
            end else begin
               parse_state = PS_TEXT;
               emit        = 1'b1;
               unit        = {8'h00, b};
            end
         end
      endcase
      if (emit)
         pending_units = {pending_units, unit};
   endfunction

   // send one byte, with a random gap ahead of it
   task automatic send_byte(input logic [uesc_pkg::BYTE_W-1:0] b);
      if ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      decode_byte(b);
      bytes_sent++;
   endtask

   // hold the sender until every predicted code unit has come out
   task automatic drain_units();
      req_chan.valid <= 1'b0;
      while (pending_units.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random hex digit character, either case for letters
   function automatic logic [uesc_pkg::BYTE_W-1:0] rand_hex_char();
      int v;
      v = $urandom_range(15);
      if (v < 10)
         return uesc_pkg::CHAR_0 + v[7:0];
      else if ($urandom_range(1))
         return uesc_pkg::CHAR_LOWER_A + v[7:0] - 8'd10;
      else
         return uesc_pkg::CHAR_UPPER_A + v[7:0] - 8'd10;
   endfunction

   // result side: check each transaction, then pick the next ready
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_units.size() == 0) begin
               error_count++;
               $display("%0t: unexpected code unit, expected none, actual %h", $time,
                        rsp_chan.code_unit);
            end else begin
               oldest_unit = pending_units.pop_front();
               units_checked++;
               if (rsp_chan.code_unit !== oldest_unit) begin
                  error_count++;
                  $display("%0t: code_unit mismatch, expected %h, actual %h", $time,
                           oldest_unit, rsp_chan.code_unit);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // plain bytes at both ends of the range
   task automatic test_plain_bytes();
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   // short escapes, escaped backslash and an escaped unknown byte
   task automatic test_short_escapes();
      send_byte(uesc_pkg::CHAR_BACKSLASH); send_byte(uesc_pkg::CHAR_T);
      send_byte(uesc_pkg::CHAR_BACKSLASH); send_byte(uesc_pkg::CHAR_R);
      send_byte(uesc_pkg::CHAR_BACKSLASH); send_byte(uesc_pkg::CHAR_N);
      send_byte(uesc_pkg::CHAR_BACKSLASH); send_byte(uesc_pkg::CHAR_F);
      send_byte(uesc_pkg::CHAR_BACKSLASH); send_byte(uesc_pkg::CHAR_BACKSLASH);
      send_byte(uesc_pkg::CHAR_BACKSLASH); send_byte(8'hFF);
   endtask

   // hex escapes: mixed case with a non-hex slot, and a stall mid escape
   task automatic test_hex_escapes();
      send_byte(uesc_pkg::CHAR_BACKSLASH); send_byte(uesc_pkg::CHAR_U);
      send_byte(uesc_pkg::CHAR_LOWER_A);   send_byte(uesc_pkg::CHAR_UPPER_F);
      send_byte(8'h67);                    send_byte(uesc_pkg::CHAR_9);
      send_byte(uesc_pkg::CHAR_BACKSLASH); send_byte(uesc_pkg::CHAR_U);
      send_byte(uesc_pkg::CHAR_UPPER_F);   send_byte(uesc_pkg::CHAR_LOWER_F);
      drain_units();
      send_byte(uesc_pkg::CHAR_UPPER_F);   send_byte(uesc_pkg::CHAR_UPPER_F);
   endtask

   // random stream, mostly well-formed escapes with random content
   task automatic test_random_stream(input int req_pct, input int rsp_pct,
                                     input int n_bytes);
      int stop_at;
      int pick;
      stop_at      = bytes_sent + n_bytes;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_byte(8'($urandom_range(255)));
         end else if (pick < 55) begin
            send_byte(uesc_pkg::CHAR_BACKSLASH);
            case ($urandom_range(3))
               0:       send_byte(uesc_pkg::CHAR_T);
               1:       send_byte(uesc_pkg::CHAR_R);
               2:       send_byte(uesc_pkg::CHAR_N);
               default: send_byte(uesc_pkg::CHAR_F);
            endcase
         end else if (pick < 65) begin
            send_byte(uesc_pkg::CHAR_BACKSLASH);
            send_byte(8'($urandom_range(255)));
         end else if (pick < 95) begin
            send_byte(uesc_pkg::CHAR_BACKSLASH);
            send_byte(uesc_pkg::CHAR_U);
            repeat (HEX_DIGITS) begin
               if ($urandom_range(9) == 0)
                  send_byte(8'($urandom_range(255)));
               else
                  send_byte(rand_hex_char());
            end
         end else begin
            // stray escape starters that break up sequences
            send_byte($urandom_range(1) ? uesc_pkg::CHAR_BACKSLASH : uesc_pkg::CHAR_U);
         end
      end
   endtask

   // main sequence
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_plain_bytes();
      test_short_escapes();
      test_hex_escapes();
      test_random_stream(7, 78, 608);
      drain_units();
      test_random_stream(78, 7, 608);
      drain_units();
      test_random_stream(0, 0, 608);

      drain_units();
      $display("covered %0d bytes in, %0d code units checked", bytes_sent, units_checked);
      $display("of those %0d from hex escapes and %0d from short escapes, %0d errors",
               hex_units, short_units, error_count);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
sv/uesc_pkg.sv
sv/uesc_if.sv
sv/unicode_escape_decoder.sv
tb/sv/tb_top.sv
